/* rtl/lpr_pkg.sv */
// Shared constants and types for the longest prefix route lookup.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int ROUTE_ENTRIES = 1024;
    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 4;
    localparam int CFG_W   = 11;
    localparam int EIDX_W  = 10;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef struct packed {
        logic write;
        logic start;
        logic scan;
        logic fetch;
        logic load;
    } lpr_cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic scan_last;
        logic out_free;
    } lpr_status_t;

endpackage

`default_nettype wire

/* rtl/longest_prefix_route_lookup.sv */
// Top level of the longest prefix route lookup over a linear route table.
//
// Input channel (in_valid/in_ready) carries one word per item. A write word
// (operation 0) stores prefix, mask, next hop and port at entry_index in the
// cycle it is accepted and returns nothing; an index beyond the table is
// dropped. A lookup word (operation 1) scans entries 0 to N-1, where N is
// entries_in_use capped at the table depth, one entry per cycle through the
// single read port of the table memory. Another word is taken only after the
// current lookup has moved its result into the output register; writes are
// taken back to back. Output channel (out_valid/out_ready) holds the result
// in a register. When the receiver stalls the result holds, the next word
// may still be accepted, and a following lookup waits at its end until the
// register is free. cfg_wr_en/cfg_wr_data write entries_in_use; the user does
// so only while the block is idle, which the block itself does not enforce.
// Reset clears entries_in_use, the controller and the output valid; the
// table contents are not cleared and must be written before they are scanned.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_lookup (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lpr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       operation,
    input  wire logic [lpr_pkg::EIDX_W-1:0] entry_index,
    input  wire logic [lpr_pkg::ADDR_W-1:0] route_prefix,
    input  wire logic [lpr_pkg::ADDR_W-1:0] route_mask,
    input  wire logic [lpr_pkg::ADDR_W-1:0] route_next_hop,
    input  wire logic [lpr_pkg::PORT_W-1:0] route_port,
    input  wire logic [lpr_pkg::ADDR_W-1:0] dest_addr,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            found,
    output logic [lpr_pkg::ADDR_W-1:0]      best_next_hop,
    output logic [lpr_pkg::PORT_W-1:0]      best_port,
    output logic [lpr_pkg::EIDX_W-1:0]      best_index
);

    lpr_pkg::lpr_cmd_t    cmd;
    lpr_pkg::lpr_status_t status;

    lpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lpr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .entry_index    (entry_index),
        .route_prefix   (route_prefix),
        .route_mask     (route_mask),
        .route_next_hop (route_next_hop),
        .route_port     (route_port),
        .dest_addr      (dest_addr),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .found          (found),
        .best_next_hop  (best_next_hop),
        .best_port      (best_port),
        .best_index     (best_index)
    );

endmodule

`default_nettype wire

/* rtl/lpr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lpr_ctrl.sv */
// Controller state machine that sequences writes, table scans and result loads.
`timescale 1ns / 1ps
`default_nettype none

module lpr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 operation,
    output logic                      in_ready,
    input  wire lpr_pkg::lpr_status_t status,
    output lpr_pkg::lpr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == lpr_pkg::OP_WRITE))
                begin
                    cmd.write = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.limit_zero ? ST_LOAD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpr_datapath.sv */
// Datapath: route table memory, scan counter, match compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module lpr_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lpr_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic [lpr_pkg::EIDX_W-1:0]          entry_index,
    input  wire logic [lpr_pkg::ADDR_W-1:0]          route_prefix,
    input  wire logic [lpr_pkg::ADDR_W-1:0]          route_mask,
    input  wire logic [lpr_pkg::ADDR_W-1:0]          route_next_hop,
    input  wire logic [lpr_pkg::PORT_W-1:0]          route_port,
    input  wire logic [lpr_pkg::ADDR_W-1:0]          dest_addr,
    input  wire lpr_pkg::lpr_cmd_t                   cmd,
    output lpr_pkg::lpr_status_t                     status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     found,
    output logic [lpr_pkg::ADDR_W-1:0]               best_next_hop,
    output logic [lpr_pkg::PORT_W-1:0]               best_port,
    output logic [lpr_pkg::EIDX_W-1:0]               best_index
);

    logic [lpr_pkg::CFG_W-1:0]  entries_in_use_reg;
    logic [lpr_pkg::CNT_W-1:0]  limit_reg;
    logic [lpr_pkg::IDX_W-1:0]  scan_idx_reg;
    logic [lpr_pkg::IDX_W-1:0]  cmp_idx_reg;
    logic                       cmp_valid_reg;
    logic [lpr_pkg::ADDR_W-1:0] dest_reg;
    logic                       hit_reg;
    logic [lpr_pkg::ADDR_W-1:0] best_mask_reg;
    logic [lpr_pkg::IDX_W-1:0]  best_idx_reg;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic [lpr_pkg::ADDR_W-1:0] hop_reg;
    logic [lpr_pkg::PORT_W-1:0] port_reg;
    logic [lpr_pkg::IDX_W-1:0]  index_reg;

    lpr_pkg::route_entry_t      wr_entry;
    lpr_pkg::route_entry_t      rd_entry;
    logic                       wr_en;
    logic                       rd_en;
    logic [lpr_pkg::IDX_W-1:0]  rd_addr;
    logic [lpr_pkg::CNT_W-1:0]  limit_next;
    logic                       match;
    logic                       take;

    assign wr_entry.prefix = route_prefix;
    assign wr_entry.mask   = route_mask;
    assign wr_entry.hop    = route_next_hop;
    assign wr_entry.port   = route_port;

    assign wr_en   = cmd.write && (32'(entry_index) < lpr_pkg::ROUTE_ENTRIES);
    assign rd_en   = cmd.scan || cmd.fetch;
    assign rd_addr = cmd.fetch ? best_idx_reg : scan_idx_reg;

    lpr_ram #(
        .WIDTH (lpr_pkg::ENTRY_W),
        .DEPTH (lpr_pkg::ROUTE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (lpr_pkg::IDX_W'(entry_index)),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign limit_next = (32'(entries_in_use_reg) > lpr_pkg::ROUTE_ENTRIES)
                      ? lpr_pkg::CNT_W'(lpr_pkg::ROUTE_ENTRIES)
                      : lpr_pkg::CNT_W'(entries_in_use_reg);

    assign match = cmp_valid_reg && ((dest_reg & rd_entry.mask) == rd_entry.prefix);
    assign take  = match && (!hit_reg || (rd_entry.mask >= best_mask_reg));

    assign status.limit_zero = (entries_in_use_reg == '0);
    assign status.scan_last  = ((lpr_pkg::CNT_W'(scan_idx_reg) + 1'b1) == limit_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
            cmp_valid_reg      <= 1'b0;
            hit_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entries_in_use_reg <= cfg_wr_data;
            end
            cmp_valid_reg <= cmd.scan;
            if (cmd.start)
            begin
                hit_reg <= 1'b0;
            end
            else if (take)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            limit_reg     <= limit_next;
            scan_idx_reg  <= '0;
            dest_reg      <= dest_addr;
            best_mask_reg <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (take)
            begin
                best_mask_reg <= rd_entry.mask;
                best_idx_reg  <= cmp_idx_reg;
            end
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.load)
        begin
            found_reg <= hit_reg;
            hop_reg   <= hit_reg ? rd_entry.hop : '0;
            port_reg  <= hit_reg ? rd_entry.port : '0;
            index_reg <= hit_reg ? best_idx_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign best_next_hop = hop_reg;
    assign best_port     = port_reg;
    assign best_index    = lpr_pkg::EIDX_W'(index_reg);

endmodule

`default_nettype wire

/* rtl/lpr_checker.sv */
// Port-level checker for the route lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lpr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       operation,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       found,
    input wire logic [lpr_pkg::ADDR_W-1:0] best_next_hop,
    input wire logic [lpr_pkg::PORT_W-1:0] best_port,
    input wire logic [lpr_pkg::EIDX_W-1:0] best_index
);

    // A result that is not taken stays offered with the same contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(best_next_hop) && $stable(best_port) && $stable(best_index))
        else $error("result changed while stalled");

    // A miss reports all-zero route fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> best_next_hop == '0 && best_port == '0
            && best_index == '0)
        else $error("miss with nonzero route fields");

    // A lookup occupies the block, so input is closed in the next cycle.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == lpr_pkg::OP_LOOKUP |=> !in_ready)
        else $error("input open right after a lookup");

    // A table write leaves the input open in the next cycle.
    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == lpr_pkg::OP_WRITE |=> in_ready)
        else $error("input closed after a write");

endmodule

bind longest_prefix_route_lookup lpr_checker u_lpr_checker (.*);

`default_nettype wire
